// ===== hw/rtl/llg_pkg.sv =====
// Shared types, constants and saturating helpers for the LLG spin-torque datapath.
// Used by llg_mul, llg_div and llg_spin_torque_rhs; no dependencies.
package llg_pkg;

	localparam int W_IN   = 32;   // Q16.16 vector components and beta
	localparam int W_DAMP = 31;   // unsigned Q15.16 damping
	localparam int W_CFG  = 40;   // Q24.16 gamma and u0
	localparam int W_OUT  = 48;   // Q32.16 result components
	localparam int W_INT  = 64;   // internal Q48.16
	localparam int W_ADDR = 2;
	localparam int FRAC   = 16;

	localparam int DVD_W   = W_CFG + FRAC;   // dividend bits, one quotient bit per stage
	localparam int MUL_LAT = 3;
	localparam int DIV_LAT = DVD_W + 2;

	localparam logic [W_ADDR-1:0] REG_BETA  = 2'd0;
	localparam logic [W_ADDR-1:0] REG_U0    = 2'd1;
	localparam logic [W_ADDR-1:0] REG_GAMMA = 2'd2;

	typedef logic signed [W_INT-1:0] fix_t;
	typedef logic signed [W_OUT-1:0] out_t;

	localparam fix_t FIX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam fix_t ONE_Q16 = 64'sd65536;
	localparam fix_t SIX_Q16 = 64'sd393216;
	localparam fix_t OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam fix_t OUT_MIN = -64'sh0000_8000_0000_0000;

	// saturating add/sub, symmetric range +-FIX_MAX
	function automatic fix_t sadd(input fix_t a, input fix_t b);
		logic signed [W_INT:0] s;
		s = {a[W_INT-1], a} + {b[W_INT-1], b};
		if (s > $signed({1'b0, FIX_MAX}))
			return FIX_MAX;
		else if (s < -$signed({1'b0, FIX_MAX}))
			return -FIX_MAX;
		else
			return s[W_INT-1:0];
	endfunction

	function automatic fix_t ssub(input fix_t a, input fix_t b);
		logic signed [W_INT:0] s;
		s = {a[W_INT-1], a} - {b[W_INT-1], b};
		if (s > $signed({1'b0, FIX_MAX}))
			return FIX_MAX;
		else if (s < -$signed({1'b0, FIX_MAX}))
			return -FIX_MAX;
		else
			return s[W_INT-1:0];
	endfunction

	function automatic out_t sat_out(input fix_t v);
		fix_t t;
		t = v;
		if (t > OUT_MAX)
			t = OUT_MAX;
		if (t < OUT_MIN)
			t = OUT_MIN;
		return t[W_OUT-1:0];
	endfunction

endpackage

// ===== hw/rtl/llg_mul.sv =====
// Pipelined 64x64 signed multiplier: Q16 truncated, saturated product and the
// exact magnitude product, both registered behind the product stages. Uses llg_pkg.
module llg_mul (
	input  logic                          clk,
	input  llg_pkg::fix_t                 a,
	input  llg_pkg::fix_t                 b,
	output llg_pkg::fix_t                 p,
	output logic [2*llg_pkg::W_INT-1:0]   sq
);
	import llg_pkg::*;

	localparam int HW = W_INT / 2;

	logic [W_INT-1:0]   ua, ub;
	logic [W_INT-1:0]   pll_s1, plh_s1, phl_s1, phh_s1;
	logic               neg_s1, neg_s2;
	logic [2*W_INT-1:0] full_s2;
	logic               sat;
	logic [W_INT-1:0]   mag;

	assign ua = a[W_INT-1] ? W_INT'(~a + 1'b1) : W_INT'(a);
	assign ub = b[W_INT-1] ? W_INT'(~b + 1'b1) : W_INT'(b);

	// anything at or above bit 63 after the shift saturates
	assign sat = |full_s2[2*W_INT-1:W_INT+FRAC-1];
	assign mag = sat ? W_INT'(FIX_MAX) : {1'b0, full_s2[W_INT+FRAC-2:FRAC]};

	always_ff @(posedge clk) begin
		pll_s1  <= ua[HW-1:0] * ub[HW-1:0];
		plh_s1  <= ua[HW-1:0] * ub[W_INT-1:HW];
		phl_s1  <= ua[W_INT-1:HW] * ub[HW-1:0];
		phh_s1  <= ua[W_INT-1:HW] * ub[W_INT-1:HW];
		neg_s1  <= a[W_INT-1] ^ b[W_INT-1];
		full_s2 <= {{W_INT{1'b0}}, pll_s1}
			+ ({{W_INT{1'b0}}, plh_s1} << HW)
			+ ({{W_INT{1'b0}}, phl_s1} << HW)
			+ {phh_s1, {W_INT{1'b0}}};
		neg_s2  <= neg_s1;
		p       <= neg_s2 ? -fix_t'(mag) : fix_t'(mag);
		sq      <= full_s2;
	end

endmodule

// ===== hw/rtl/llg_div.sv =====
// Pipelined restoring divider: quo = +-((num << 16) / den), truncated toward zero,
// one quotient bit per stage. Uses llg_pkg.
module llg_div (
	input  logic                              clk,
	input  llg_pkg::fix_t                     den,
	input  logic signed [llg_pkg::W_CFG-1:0]  num,
	input  logic                              negate,
	output llg_pkg::fix_t                     quo
);
	import llg_pkg::*;

	logic [W_INT-1:0] rem_s [0:DVD_W];
	logic [DVD_W-1:0] dvd_s [0:DVD_W];
	logic [DVD_W-1:0] q_s   [0:DVD_W];
	logic [W_INT-1:0] den_s [0:DVD_W];
	logic             neg_s [0:DVD_W];
	logic [W_CFG-1:0] unum;
	fix_t             qx;

	assign unum = num[W_CFG-1] ? W_CFG'(~num + 1'b1) : W_CFG'(num);
	assign qx   = {{(W_INT-DVD_W){1'b0}}, q_s[DVD_W]};

	always_ff @(posedge clk) begin
		rem_s[0] <= '0;
		dvd_s[0] <= {unum, {FRAC{1'b0}}};
		q_s[0]   <= '0;
		den_s[0] <= W_INT'(den);
		neg_s[0] <= num[W_CFG-1] ^ negate;
		quo      <= neg_s[DVD_W] ? -qx : qx;
	end

	// remainder stays below den (< 2^63), so its top bit can be dropped on the shift
	for (genvar i = 0; i < DVD_W; i++) begin : g_step
		logic [W_INT-1:0] trial;
		logic             ge;
		assign trial = {rem_s[i][W_INT-2:0], dvd_s[i][DVD_W-1]};
		assign ge    = trial >= den_s[i];
		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? trial - den_s[i] : trial;
			dvd_s[i+1] <= {dvd_s[i][DVD_W-2:0], 1'b0};
			q_s[i+1]   <= {q_s[i][DVD_W-2:0], ge};
			den_s[i+1] <= den_s[i];
			neg_s[i+1] <= neg_s[i];
		end
	end

endmodule

// ===== hw/rtl/llg_spin_torque_rhs.sv =====
// LLG + Zhang-Li spin-torque right-hand side, one site per clock.
// done is raised as the valid bit of a taken start leaves the delay line, whose length is
// set by the 58-stage divider for the 1/(1+a^2) coefficients and the 64-stage
// square root of |dm|^2. Throughput: one transaction per cycle, busy stays low.
// The receiver cannot stall: each result is shown for one cycle with done.
// Reset clears the valid pipeline, done and the three config registers.
module llg_spin_torque_rhs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [llg_pkg::W_IN-1:0]     mag_x,
	input  logic signed [llg_pkg::W_IN-1:0]     mag_y,
	input  logic signed [llg_pkg::W_IN-1:0]     mag_z,
	input  logic signed [llg_pkg::W_IN-1:0]     heff_x,
	input  logic signed [llg_pkg::W_IN-1:0]     heff_y,
	input  logic signed [llg_pkg::W_IN-1:0]     heff_z,
	input  logic signed [llg_pkg::W_IN-1:0]     torque_field_x,
	input  logic signed [llg_pkg::W_IN-1:0]     torque_field_y,
	input  logic signed [llg_pkg::W_IN-1:0]     torque_field_z,
	input  logic [llg_pkg::W_DAMP-1:0]          damping,
	input  logic                                last_site_in,
	output logic                                done,
	output llg_pkg::out_t                       rate_x,
	output llg_pkg::out_t                       rate_y,
	output llg_pkg::out_t                       rate_z,
	output logic                                last_site_out,
	input  logic                                cfg_we,
	input  logic [llg_pkg::W_ADDR-1:0]          cfg_addr,
	input  logic [llg_pkg::W_CFG-1:0]           cfg_wdata
);
	import llg_pkg::*;

	// stage at which each value sits in its register
	localparam int T_SUM2 = MUL_LAT + 2;
	localparam int T_DEN  = MUL_LAT + 1;
	localparam int T_OM   = T_SUM2 + 1;
	localparam int T_K    = T_DEN + DIV_LAT;
	localparam int T_HP   = T_SUM2 + MUL_LAT + 1;
	localparam int T_MX   = T_HP + MUL_LAT + 1;
	localparam int T_EH   = T_MX + 1;
	localparam int T_ES   = T_MX + MUL_LAT + 1;
	localparam int T_DM   = T_K + MUL_LAT + 1;
	localparam int T_N    = T_DM + MUL_LAT + 2;
	localparam int T_NRM  = T_N + W_INT + 1;
	localparam int T_CN   = T_NRM + MUL_LAT;
	localparam int T_W    = T_CN + MUL_LAT;
	localparam int T_WM   = T_W + MUL_LAT;
	localparam int T_OUT  = T_WM + 1;
	localparam int W_SQ   = 2 * W_INT;

	function automatic fix_t sx(input logic signed [W_IN-1:0] v);
		return {{(W_INT-W_IN){v[W_IN-1]}}, v};
	endfunction

	function automatic fix_t ux(input logic [W_DAMP-1:0] v);
		return {{(W_INT-W_DAMP){1'b0}}, v};
	endfunction

	// configuration
	logic signed [W_IN-1:0]  beta_q;
	logic signed [W_CFG-1:0] u0_q, gamma_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q  <= '0;
			u0_q    <= '0;
			gamma_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BETA:  beta_q  <= cfg_wdata[W_IN-1:0];
				REG_U0:    u0_q    <= cfg_wdata;
				REG_GAMMA: gamma_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// input stage and delay lines
	logic                    vld_s  [0:T_OUT-1];
	logic                    last_s [0:T_OUT-1];
	logic signed [W_IN-1:0]  mag_s  [0:T_W][3];
	logic signed [W_IN-1:0]  heff_s [0:T_SUM2][3];
	logic signed [W_IN-1:0]  tqf_s  [0:T_SUM2][3];
	logic [W_DAMP-1:0]       damp_s [0:T_MX-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < T_OUT; i++)
				vld_s[i] <= 1'b0;
		end else begin
			vld_s[0] <= start && !busy;
			for (int i = 1; i < T_OUT; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		last_s[0]    <= last_site_in;
		mag_s[0][0]  <= mag_x;
		mag_s[0][1]  <= mag_y;
		mag_s[0][2]  <= mag_z;
		heff_s[0][0] <= heff_x;
		heff_s[0][1] <= heff_y;
		heff_s[0][2] <= heff_z;
		tqf_s[0][0]  <= torque_field_x;
		tqf_s[0][1]  <= torque_field_y;
		tqf_s[0][2]  <= torque_field_z;
		damp_s[0]    <= damping;
		for (int i = 1; i < T_OUT; i++)
			last_s[i] <= last_s[i-1];
		for (int i = 1; i <= T_W; i++)
			mag_s[i] <= mag_s[i-1];
		for (int i = 1; i <= T_SUM2; i++) begin
			heff_s[i] <= heff_s[i-1];
			tqf_s[i]  <= tqf_s[i-1];
		end
		for (int i = 1; i < T_MX; i++)
			damp_s[i] <= damp_s[i-1];
	end

	// a^2, a*beta and the three dot products
	fix_t aa_p, ab_p;
	fix_t mm_p [3];
	fix_t mh_p [3];
	fix_t ms_p [3];

	llg_mul u_aa (.clk, .a(ux(damp_s[0])), .b(ux(damp_s[0])), .p(aa_p), .sq());
	llg_mul u_ab (.clk, .a(ux(damp_s[0])), .b(sx(beta_q)), .p(ab_p), .sq());

	for (genvar c = 0; c < 3; c++) begin : g_dot
		llg_mul u_mm (.clk, .a(sx(mag_s[0][c])), .b(sx(mag_s[0][c])), .p(mm_p[c]), .sq());
		llg_mul u_mh (.clk, .a(sx(mag_s[0][c])), .b(sx(heff_s[0][c])), .p(mh_p[c]), .sq());
		llg_mul u_ms (.clk, .a(sx(mag_s[0][c])), .b(sx(tqf_s[0][c])), .p(ms_p[c]), .sq());
	end

	fix_t den_s4, mm01_s4, mh01_s4, ms01_s4, mm2_s4, mh2_s4, ms2_s4;
	fix_t mm_s5, mh_s5, ms_s5;
	fix_t f1_s [T_DEN:T_HP];
	fix_t om_s [T_OM:T_CN];

	always_ff @(posedge clk) begin
		den_s4      <= sadd(ONE_Q16, aa_p);
		f1_s[T_DEN] <= sadd(ONE_Q16, ab_p);
		mm01_s4     <= sadd(mm_p[0], mm_p[1]);
		mh01_s4     <= sadd(mh_p[0], mh_p[1]);
		ms01_s4     <= sadd(ms_p[0], ms_p[1]);
		mm2_s4      <= mm_p[2];
		mh2_s4      <= mh_p[2];
		ms2_s4      <= ms_p[2];
		mm_s5       <= sadd(mm01_s4, mm2_s4);
		mh_s5       <= sadd(mh01_s4, mh2_s4);
		ms_s5       <= sadd(ms01_s4, ms2_s4);
		om_s[T_OM]  <= ssub(ONE_Q16, mm_s5);
		for (int i = T_DEN + 1; i <= T_HP; i++)
			f1_s[i] <= f1_s[i-1];
		for (int i = T_OM + 1; i <= T_CN; i++)
			om_s[i] <= om_s[i-1];
	end

	// coefficients: -gamma/(1+a^2) and u0/(1+a^2)
	fix_t k_llg, k_stt;

	llg_div u_div_llg (.clk, .den(den_s4), .num(gamma_q), .negate(1'b1), .quo(k_llg));
	llg_div u_div_stt (.clk, .den(den_s4), .num(u0_q), .negate(1'b0), .quo(k_stt));

	// perpendicular parts, cross products and bracket terms
	fix_t pha [3];
	fix_t phb [3];
	fix_t psa [3];
	fix_t psb [3];
	fix_t hph_s9 [3];
	fix_t hps_s9 [3];
	fix_t xha [3];
	fix_t xhb [3];
	fix_t xsa [3];
	fix_t xsb [3];
	fix_t hpa [3];
	fix_t f1hp [3];
	fix_t f2mx [3];
	fix_t mxh_s13 [3];
	fix_t mxs_s13 [3];
	fix_t hpa_s13 [3];
	fix_t f2_s13;
	fix_t f1hp_s [T_MX:T_ES-1][3];
	fix_t eh_s [T_EH:T_K][3];
	fix_t es_s [T_ES:T_K][3];

	for (genvar c = 0; c < 3; c++) begin : g_vec
		localparam int C1 = (c + 1) % 3;
		localparam int C2 = (c + 2) % 3;

		llg_mul u_pha (.clk, .a(mm_s5), .b(sx(heff_s[T_SUM2][c])), .p(pha[c]), .sq());
		llg_mul u_phb (.clk, .a(mh_s5), .b(sx(mag_s[T_SUM2][c])), .p(phb[c]), .sq());
		llg_mul u_psa (.clk, .a(mm_s5), .b(sx(tqf_s[T_SUM2][c])), .p(psa[c]), .sq());
		llg_mul u_psb (.clk, .a(ms_s5), .b(sx(mag_s[T_SUM2][c])), .p(psb[c]), .sq());

		llg_mul u_xha (.clk, .a(sx(mag_s[T_HP][C1])), .b(hph_s9[C2]), .p(xha[c]), .sq());
		llg_mul u_xhb (.clk, .a(sx(mag_s[T_HP][C2])), .b(hph_s9[C1]), .p(xhb[c]), .sq());
		llg_mul u_xsa (.clk, .a(sx(mag_s[T_HP][C1])), .b(hps_s9[C2]), .p(xsa[c]), .sq());
		llg_mul u_xsb (.clk, .a(sx(mag_s[T_HP][C2])), .b(hps_s9[C1]), .p(xsb[c]), .sq());

		llg_mul u_hpa (.clk, .a(hph_s9[c]), .b(ux(damp_s[T_HP])), .p(hpa[c]), .sq());
		llg_mul u_f1hp (.clk, .a(f1_s[T_HP]), .b(hps_s9[c]), .p(f1hp[c]), .sq());
		llg_mul u_f2mx (.clk, .a(f2_s13), .b(mxs_s13[c]), .p(f2mx[c]), .sq());

		always_ff @(posedge clk) begin
			hph_s9[c]        <= ssub(pha[c], phb[c]);
			hps_s9[c]        <= ssub(psa[c], psb[c]);
			mxh_s13[c]       <= ssub(xha[c], xhb[c]);
			mxs_s13[c]       <= ssub(xsa[c], xsb[c]);
			hpa_s13[c]       <= hpa[c];
			f1hp_s[T_MX][c]  <= f1hp[c];
			for (int i = T_MX + 1; i < T_ES; i++)
				f1hp_s[i][c] <= f1hp_s[i-1][c];
			eh_s[T_EH][c]    <= ssub(mxh_s13[c], hpa_s13[c]);
			for (int i = T_EH + 1; i <= T_K; i++)
				eh_s[i][c] <= eh_s[i-1][c];
			es_s[T_ES][c]    <= ssub(f1hp_s[T_ES-1][c], f2mx[c]);
			for (int i = T_ES + 1; i <= T_K; i++)
				es_s[i][c] <= es_s[i-1][c];
		end
	end

	always_ff @(posedge clk)
		f2_s13 <= ssub(sx(beta_q), ux(damp_s[T_MX-1]));

	// dm = k_llg * eh + k_stt * es
	fix_t tl [3];
	fix_t ts [3];
	fix_t dm_s [T_DM:T_WM][3];
	logic [W_SQ-1:0] sqf [3];

	for (genvar c = 0; c < 3; c++) begin : g_dm
		llg_mul u_tl (.clk, .a(k_llg), .b(eh_s[T_K][c]), .p(tl[c]), .sq());
		llg_mul u_ts (.clk, .a(k_stt), .b(es_s[T_K][c]), .p(ts[c]), .sq());
		llg_mul u_sq (.clk, .a(dm_s[T_DM][c]), .b(dm_s[T_DM][c]), .p(), .sq(sqf[c]));

		always_ff @(posedge clk) begin
			dm_s[T_DM][c] <= sadd(tl[c], ts[c]);
			for (int i = T_DM + 1; i <= T_WM; i++)
				dm_s[i][c] <= dm_s[i-1][c];
		end
	end

	// |dm|: exact sum of squares (below 2^128), then one root bit per stage
	logic [W_SQ-1:0]  n01_s, sq2_s;
	logic [W_SQ-1:0]  sr_s [0:W_INT];
	logic [W_INT-1:0] rt_s [0:W_INT];
	fix_t             nrm_s;

	always_ff @(posedge clk) begin
		n01_s    <= sqf[0] + sqf[1];
		sq2_s    <= sqf[2];
		sr_s[0]  <= n01_s + sq2_s;
		rt_s[0]  <= '0;
		nrm_s    <= rt_s[W_INT][W_INT-1] ? FIX_MAX : fix_t'(rt_s[W_INT]);
	end

	for (genvar k = 0; k < W_INT; k++) begin : g_root
		localparam int B = W_INT - 1 - k;
		logic [W_SQ+1:0] trial;
		logic            ge;
		// (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
		assign trial = ({{(W_SQ-W_INT+2){1'b0}}, rt_s[k]} << (B + 1))
			+ ((W_SQ+2)'(1) << (2 * B));
		assign ge    = {2'b00, sr_s[k]} >= trial;
		always_ff @(posedge clk) begin
			sr_s[k+1] <= ge ? sr_s[k] - trial[W_SQ-1:0] : sr_s[k];
			rt_s[k+1] <= ge ? (rt_s[k] | (W_INT'(1) << B)) : rt_s[k];
		end
	end

	// renormalizing term 6|dm|(1 - m.m) m
	fix_t cn_p, w_p;
	fix_t wm [3];

	llg_mul u_cn (.clk, .a(SIX_Q16), .b(nrm_s), .p(cn_p), .sq());
	llg_mul u_w (.clk, .a(cn_p), .b(om_s[T_CN]), .p(w_p), .sq());

	for (genvar c = 0; c < 3; c++) begin : g_wm
		llg_mul u_wm (.clk, .a(w_p), .b(sx(mag_s[T_W][c])), .p(wm[c]), .sq());
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= vld_s[T_OUT-1];
	end

	always_ff @(posedge clk) begin
		rate_x        <= sat_out(sadd(dm_s[T_WM][0], wm[0]));
		rate_y        <= sat_out(sadd(dm_s[T_WM][1], wm[1]));
		rate_z        <= sat_out(sadd(dm_s[T_WM][2], wm[2]));
		last_site_out <= last_s[T_OUT-1];
	end

	// a result only ever follows an accepted transaction at the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, T_OUT + 1))
		else $error("result strobe without matching start");

	// 1 + a^2 is at least one, so the dividers never see a small or zero divisor
	a_den_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[T_DEN] |-> (den_s4 >= ONE_Q16))
		else $error("divisor below 1.0");

	a_zero_gamma: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[T_K] && (gamma_q == '0)) |-> (k_llg == '0))
		else $error("nonzero precession coefficient with gamma zero");

endmodule
